// ===== hdl/b64d_pkg.sv =====
`timescale 1ns / 1ps
// b64d_pkg: shared types, constants and the character lookup for the base64 decoder
// used by every module of the decoder; depends on nothing else

package b64d_pkg;

  // queue between the front and back parts
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  // character constants
  localparam logic [7:0] PAD_CHAR     = 8'h3D;  // '='
  localparam logic [7:0] PLUS_CHAR    = 8'h2B;  // '+'
  localparam logic [7:0] SLASH_CHAR   = 8'h2F;  // '/'
  localparam logic [7:0] INVALID_MARK = 8'h80;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [15:0] LIMIT_RESET = 16'd512;

  // input request payload
  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } text_t;

  // output request payload
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic        last_of_run;
  } result_t;

  // one pending result inside a bundle
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
  } slot_t;

  // all results caused by one character: three byte slots, then the status slot
  typedef struct packed {
    logic [3:0]  mask;
    slot_t [3:0] slot;
  } bundle_t;

  // character to sextet, invalid characters carry the invalid mark
  function automatic logic [7:0] sextet_of(input logic [7:0] ch);
    logic [7:0] v;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = ch - 8'h41;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = ch - 8'h61 + 8'd26;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = ch - 8'h30 + 8'd52;
    end else if (ch == PLUS_CHAR) begin
      v = 8'd62;
    end else if (ch == SLASH_CHAR) begin
      v = 8'd63;
    end else if (ch == PAD_CHAR) begin
      v = 8'd0;
    end else begin
      v = INVALID_MARK;
    end
    return v;
  endfunction

endpackage

// ===== hdl/b64d_front.sv =====
`timescale 1ns / 1ps
// b64d_front: accepts characters, collects groups of four and builds the result bundle
// depends on b64d_pkg

module b64d_front import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  text_t       text,
  input  logic [15:0] limit,
  output logic        push,
  output bundle_t     push_data,
  input  logic        full
);

  logic [17:0] store, store_next;
  logic [1:0]  pos, pos_next;
  logic        third_pad, third_pad_next;
  logic        group_bad, group_bad_next;
  logic [15:0] count, count_next;
  logic        halted, halted_next;
  logic        err, err_next;

  logic        accept;
  logic [7:0]  sx;
  logic [5:0]  s;
  logic        bad, is_end, active, fourth_pad, at_limit;
  logic [23:0] bits;
  logic [15:0] room;
  logic [1:0]  n_want, emit_lim, emit_n;

  assign accept     = text_valid && !full;
  assign text_stall = full;

  // classify the character
  assign sx         = sextet_of(text.text_char);
  assign bad        = (sx & INVALID_MARK) != 8'd0;
  assign s          = sx[5:0];
  assign is_end     = (text.text_char == 8'd0) || text.end_of_text;
  assign active     = (text.text_char != 8'd0) && !halted;
  assign fourth_pad = (text.text_char == PAD_CHAR);
  assign bits       = {store, s};

  // bytes wanted by the group and room left under the limit
  assign at_limit = count >= limit;
  assign room     = limit - count;
  assign n_want   = 2'd1 + {1'b0, !third_pad} + {1'b0, !fourth_pad};
  assign emit_lim = (room < 16'd3) ? room[1:0] : 2'd3;
  assign emit_n   = (n_want < emit_lim) ? n_want : emit_lim;

  // next state and bundle
  always_comb begin
    store_next     = store;
    pos_next       = pos;
    third_pad_next = third_pad;
    group_bad_next = group_bad;
    count_next     = count;
    halted_next    = halted;
    err_next       = err;
    push_data      = '0;

    push_data.slot[0] = '{kind: KIND_BYTE, data_byte: bits[23:16],
                          byte_count: count + 16'd1};
    push_data.slot[1] = '{kind: KIND_BYTE,
                          data_byte: third_pad ? bits[7:0] : bits[15:8],
                          byte_count: count + 16'd2};
    push_data.slot[2] = '{kind: KIND_BYTE, data_byte: bits[7:0],
                          byte_count: count + 16'd3};

    if (active) begin
      group_bad_next = group_bad || bad;
      if (pos != 2'd3) begin
        if (pos == 2'd2) begin
          third_pad_next = fourth_pad;
        end
        store_next = {store[11:0], s};
        pos_next   = pos + 2'd1;
      end else begin
        if (at_limit) begin
          halted_next = 1'b1;
        end else if (group_bad || bad) begin
          halted_next = 1'b1;
          err_next    = 1'b1;
        end else begin
          push_data.mask[0] = emit_n >= 2'd1;
          push_data.mask[1] = emit_n >= 2'd2;
          push_data.mask[2] = emit_n >= 2'd3;
          count_next        = count + {14'd0, emit_n};
          if (room <= {14'd0, emit_n}) begin
            halted_next = 1'b1;
          end
        end
        store_next     = '0;
        pos_next       = 2'd0;
        third_pad_next = 1'b0;
        group_bad_next = 1'b0;
      end
    end

    // end of string: status result and clear
    push_data.slot[3] = '{kind: err_next ? KIND_ERROR : KIND_OK, data_byte: 8'd0,
                          byte_count: count_next};
    if (is_end) begin
      push_data.mask[3] = 1'b1;
      store_next        = '0;
      pos_next          = 2'd0;
      third_pad_next    = 1'b0;
      group_bad_next    = 1'b0;
      count_next        = '0;
      halted_next       = 1'b0;
      err_next          = 1'b0;
    end
  end

  assign push = accept && (push_data.mask != 4'd0);

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      store     <= '0;
      pos       <= '0;
      third_pad <= 1'b0;
      group_bad <= 1'b0;
      count     <= '0;
      halted    <= 1'b0;
      err       <= 1'b0;
    end else if (accept) begin
      store     <= store_next;
      pos       <= pos_next;
      third_pad <= third_pad_next;
      group_bad <= group_bad_next;
      count     <= count_next;
      halted    <= halted_next;
      err       <= err_next;
    end
  end

endmodule

// ===== hdl/b64d_queue.sv =====
`timescale 1ns / 1ps
// b64d_queue: short queue of result bundles between the front and back parts
// depends on b64d_pkg

module b64d_queue import b64d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output bundle_t pop_data,
  output logic    empty
);

  bundle_t              mem [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr;
  logic [QueueAw-1:0]   rd_ptr;
  logic [QueueAw:0]     fill;

  assign full     = fill == (QueueAw+1)'(QueueDepth);
  assign empty    = fill == '0;
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= (QueueAw+1)'(QueueDepth))
    else $error("queue fill out of range");
  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> $stable(fill))
    else $error("queue fill moved without push or pop");

endmodule

// ===== hdl/b64d_back.sv =====
`timescale 1ns / 1ps
// b64d_back: takes bundles from the queue and sends their results one per cycle while the receiver does not stall
// depends on b64d_pkg

module b64d_back import b64d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  bundle_t q_data,
  input  logic    q_empty,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  slot_t [3:0] cur_slot;
  logic [3:0]  cur_mask;
  logic [3:0]  mask_after;
  logic [3:0]  sel_bit;
  logic [1:0]  sel;
  logic        out_free;

  assign out_free = !result_valid || !result_stall;

  // first pending slot
  always_comb begin
    if (cur_mask[0]) begin
      sel = 2'd0;
    end else if (cur_mask[1]) begin
      sel = 2'd1;
    end else if (cur_mask[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign sel_bit    = 4'b0001 << sel;
  assign mask_after = out_free ? (cur_mask & ~sel_bit) : cur_mask;
  assign pop        = !q_empty && (mask_after == 4'd0);

  // current bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
    end else begin
      cur_mask <= pop ? q_data.mask : mask_after;
    end
    if (pop) begin
      cur_slot <= q_data.slot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= cur_mask != 4'd0;
    end
    if (out_free && (cur_mask != 4'd0)) begin
      result.kind        <= cur_slot[sel].kind;
      result.data_byte   <= cur_slot[sel].data_byte;
      result.byte_count  <= cur_slot[sel].byte_count;
      result.last_of_run <= (cur_mask & ~sel_bit) == 4'd0;
    end
  end

  a_byte_kind_has_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_BYTE) |-> result.byte_count != 16'd0)
    else $error("decoded byte with zero count");
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind != KIND_BYTE) |-> result.last_of_run)
    else $error("status result not last of run");
  a_pop_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    pop |-> mask_after == 4'd0)
    else $error("bundle loaded over pending results");

endmodule

// ===== hdl/base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// base64_stream_decoder: top level, output limit register and the three parts
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
//
// Use:
//   text channel (text_valid / text_stall / text): one character per request,
//   with end_of_text marking the last one of a string; a zero character also
//   ends the string.
//   result channel (result_valid / result_stall / result): decoded bytes, then
//   one status result per string (finished ok or finished with error), each
//   carrying the running byte count; last_of_run flags the final result of
//   each character.
//   limit channel (limit_valid / limit_ready / limit_data): writes the output
//   byte limit per string; always ready, write it only while idle.
// Timing:
//   a character is taken every cycle while the four-entry bundle queue has room;
//   its first result passes the queue, the current bundle register and the
//   output register. Results leave one per cycle while the receiver does not
//   stall, and the queue fills when output runs behind the input.
// Reset: clears string state, queue and output register; the limit returns to 512.
// Receiver stall: the output register holds and the back part keeps the rest of
//   the current character's results, or loads one more bundle if none are left;
//   the queue takes characters that cause results until its four entries are full, then text_stall rises.

module base64_stream_decoder import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  text_t       text,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        limit_valid,
  output logic        limit_ready,
  input  logic [15:0] limit_data
);

  logic [15:0] limit;
  logic        push, pop, q_full, q_empty;
  bundle_t     push_data, q_data;

  assign limit_ready = 1'b1;

  // output limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (limit_valid && limit_ready) begin
      limit <= limit_data;
    end
  end

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .limit      (limit),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_data),
    .q_empty      (q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
